// ===== rtl/ray_sphere_intersection_top_macros.svh =====
// Assertion macros for the ray/sphere intersection block.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef RAY_SPHERE_INTERSECTION_TOP_MACROS_SVH
`define RAY_SPHERE_INTERSECTION_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rsi_pkg.sv =====
// Shared widths and pipeline payload types for the ray/sphere intersection block.
// No dependencies.
package rsi_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int CW   = COORD_BITS;       // coordinate width
  localparam int DTW  = CW - 1;           // distance and radius width
  localparam int AW   = 2 * CW;           // a = d.d, unsigned
  localparam int HW   = 2 * CW + 2;       // h = w.d, signed
  localparam int CCW  = 2 * CW + 3;       // c = w.w - r*r, signed
  localparam int DW   = 4 * CW + 3;       // non-negative discriminant
  localparam int SW   = DW + 2;           // signed width of h*h and a*c
  localparam int EW   = 2 * CW + 2;       // square root width
  localparam int NW   = 2 * CW + 4;       // root numerator, signed
  localparam int DVW  = AW + DTW + 1;     // divider remainder width

  // Operand splits for the wide products.
  localparam int HLW  = CW + 1;
  localparam int HHW  = HW - HLW;
  localparam int ALW  = CW;
  localparam int AHW  = AW - ALW;
  localparam int CLW  = CW + 1;
  localparam int CHW  = CCW - CLW;

  // Quadratic terms leaving the front end.
  typedef struct packed {
    logic                 vld;
    logic                 nohit;
    logic signed [HW-1:0] h;
    logic [AW-1:0]        a;
    logic [DW-1:0]        disc;
  } quad_t;

  // Quadratic terms with the discriminant's square root.
  typedef struct packed {
    logic                 vld;
    logic                 nohit;
    logic signed [HW-1:0] h;
    logic [AW-1:0]        a;
    logic [EW-1:0]        root;
  } root_t;

  // Finished result.
  typedef struct packed {
    logic           vld;
    logic           hit;
    logic [DTW-1:0] distance;
  } res_t;

endpackage

// ===== rtl/rsi_quad.sv =====
// Front end: forms a, h, c and the quarter discriminant over six stages.
// Depends on rsi_pkg.
module rsi_quad (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [2:0][rsi_pkg::CW-1:0]   dir_i,
  input  logic [2:0][rsi_pkg::CW-1:0]   org_i,
  input  logic [2:0][rsi_pkg::CW-1:0]   ctr_i,
  input  logic [rsi_pkg::DTW-1:0]       rad_i,
  output rsi_pkg::quad_t                q_o
);
  import rsi_pkg::*;

  // Stage 1: direction, offset from the center, radius.
  logic                  s1_vld_r;
  logic signed [CW-1:0]  s1_d_r   [3];
  logic signed [CW:0]    s1_w_r   [3];
  logic signed [CW:0]    s1_w_nxt [3];
  logic [DTW-1:0]        s1_r_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s1_w_nxt[j] = $signed({org_i[j][CW-1], org_i[j]}) - $signed({ctr_i[j][CW-1], ctr_i[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s1_d_r[j] <= $signed(dir_i[j]);
        s1_w_r[j] <= s1_w_nxt[j];
      end
      s1_r_r <= rad_i;
    end
  end

  // Stage 2: per-axis products.
  logic                    s2_vld_r;
  logic signed [2*CW-1:0]  s2_dd_r   [3];
  logic signed [2*CW:0]    s2_wd_r   [3];
  logic signed [2*CW+1:0]  s2_ww_r   [3];
  logic [2*DTW-1:0]        s2_rr_r;
  logic signed [2*CW-1:0]  s2_dd_nxt [3];
  logic signed [2*CW:0]    s2_wd_nxt [3];
  logic signed [2*CW+1:0]  s2_ww_nxt [3];
  logic [2*DTW-1:0]        s2_rr_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s2_dd_nxt[j] = s1_d_r[j] * s1_d_r[j];
      s2_wd_nxt[j] = s1_w_r[j] * s1_d_r[j];
      s2_ww_nxt[j] = s1_w_r[j] * s1_w_r[j];
    end
    s2_rr_nxt = s1_r_r * s1_r_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s2_dd_r[j] <= s2_dd_nxt[j];
        s2_wd_r[j] <= s2_wd_nxt[j];
        s2_ww_r[j] <= s2_ww_nxt[j];
      end
      s2_rr_r <= s2_rr_nxt;
    end
  end

  // Stage 3: dot products a, h and c.
  logic                  s3_vld_r;
  logic [AW-1:0]         s3_a_r, s3_a_nxt;
  logic signed [HW-1:0]  s3_h_r, s3_h_nxt;
  logic signed [CCW-1:0] s3_c_r, s3_c_nxt;

  always_comb begin
    s3_a_nxt = $unsigned(s2_dd_r[0]) + $unsigned(s2_dd_r[1]) + $unsigned(s2_dd_r[2]);
    s3_h_nxt = HW'(s2_wd_r[0]) + HW'(s2_wd_r[1]) + HW'(s2_wd_r[2]);
    s3_c_nxt = CCW'(s2_ww_r[0]) + CCW'(s2_ww_r[1]) + CCW'(s2_ww_r[2])
             - CCW'($signed({1'b0, s2_rr_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a_r <= s3_a_nxt;
      s3_h_r <= s3_h_nxt;
      s3_c_r <= s3_c_nxt;
    end
  end

  // Stage 4: partial products of h*h and a*c.
  logic                         s4_vld_r, s4_nohit_r;
  logic signed [HW-1:0]         s4_h_r;
  logic [AW-1:0]                s4_a_r;
  logic [2*HLW-1:0]             s4_hll_r, s4_hll_nxt;
  logic signed [HLW+HHW:0]      s4_hlh_r, s4_hlh_nxt;
  logic signed [2*HHW-1:0]      s4_hhh_r, s4_hhh_nxt;
  logic [ALW+CLW-1:0]           s4_alcl_r, s4_alcl_nxt;
  logic signed [ALW+CHW:0]      s4_alch_r, s4_alch_nxt;
  logic [AHW+CLW-1:0]           s4_ahcl_r, s4_ahcl_nxt;
  logic signed [AHW+CHW:0]      s4_ahch_r, s4_ahch_nxt;
  logic [HLW-1:0]               hl;
  logic signed [HHW-1:0]        hh;
  logic [ALW-1:0]               al;
  logic [AHW-1:0]               ah;
  logic [CLW-1:0]               cl;
  logic signed [CHW-1:0]        ch;

  always_comb begin
    hl = s3_h_r[HLW-1:0];
    hh = s3_h_r[HW-1:HLW];
    al = s3_a_r[ALW-1:0];
    ah = s3_a_r[AW-1:ALW];
    cl = s3_c_r[CLW-1:0];
    ch = s3_c_r[CCW-1:CLW];
    s4_hll_nxt  = hl * hl;
    s4_hlh_nxt  = $signed({1'b0, hl}) * hh;
    s4_hhh_nxt  = hh * hh;
    s4_alcl_nxt = al * cl;
    s4_alch_nxt = $signed({1'b0, al}) * ch;
    s4_ahcl_nxt = ah * cl;
    s4_ahch_nxt = $signed({1'b0, ah}) * ch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nohit_r <= (s3_a_r == '0);
      s4_h_r     <= s3_h_r;
      s4_a_r     <= s3_a_r;
      s4_hll_r   <= s4_hll_nxt;
      s4_hlh_r   <= s4_hlh_nxt;
      s4_hhh_r   <= s4_hhh_nxt;
      s4_alcl_r  <= s4_alcl_nxt;
      s4_alch_r  <= s4_alch_nxt;
      s4_ahcl_r  <= s4_ahcl_nxt;
      s4_ahch_r  <= s4_ahch_nxt;
    end
  end

  // Stage 5: recombine the partial products.
  logic                 s5_vld_r, s5_nohit_r;
  logic signed [HW-1:0] s5_h_r;
  logic [AW-1:0]        s5_a_r;
  logic signed [SW-1:0] s5_hh_r, s5_hh_nxt;
  logic signed [SW-1:0] s5_ac_r, s5_ac_nxt;

  always_comb begin
    s5_hh_nxt = (SW'(s4_hhh_r) <<< (2 * HLW))
              + (SW'(s4_hlh_r) <<< (HLW + 1))
              + SW'($signed({1'b0, s4_hll_r}));
    s5_ac_nxt = (SW'(s4_ahch_r) <<< (ALW + CLW))
              + (SW'($signed({1'b0, s4_ahcl_r})) <<< ALW)
              + (SW'(s4_alch_r) <<< CLW)
              + SW'($signed({1'b0, s4_alcl_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_nohit_r <= s4_nohit_r;
      s5_h_r     <= s4_h_r;
      s5_a_r     <= s4_a_r;
      s5_hh_r    <= s5_hh_nxt;
      s5_ac_r    <= s5_ac_nxt;
    end
  end

  // Stage 6: discriminant; a negative one means no hit.
  logic                 s6_vld_r, s6_nohit_r;
  logic signed [HW-1:0] s6_h_r;
  logic [AW-1:0]        s6_a_r;
  logic [DW-1:0]        s6_disc_r;
  logic signed [SW-1:0] disc_full;

  assign disc_full = s5_hh_r - s5_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_nohit_r <= s5_nohit_r | disc_full[SW-1];
      s6_h_r     <= s5_h_r;
      s6_a_r     <= s5_a_r;
      s6_disc_r  <= disc_full[SW-1] ? '0 : disc_full[DW-1:0];
    end
  end

  assign q_o.vld   = s6_vld_r;
  assign q_o.nohit = s6_nohit_r;
  assign q_o.h     = s6_h_r;
  assign q_o.a     = s6_a_r;
  assign q_o.disc  = s6_disc_r;

endmodule

// ===== rtl/rsi_sqrt.sv =====
// Floor square root of the discriminant, one result bit per pipeline stage.
// Depends on rsi_pkg.
module rsi_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  rsi_pkg::quad_t  q_i,
  output rsi_pkg::root_t  r_o
);
  import rsi_pkg::*;

  logic [DW-1:0]        rem_w   [EW+1];
  logic [EW-1:0]        root_w  [EW+1];
  logic signed [HW-1:0] h_w     [EW+1];
  logic [AW-1:0]        a_w     [EW+1];
  logic                 vld_w   [EW+1];
  logic                 nohit_w [EW+1];

  assign rem_w[0]   = q_i.disc;
  assign root_w[0]  = '0;
  assign h_w[0]     = q_i.h;
  assign a_w[0]     = q_i.a;
  assign vld_w[0]   = q_i.vld;
  assign nohit_w[0] = q_i.nohit;

  // Each stage tries one root bit: (e + 2^k)^2 <= D holds when 2^(k+1)*e + 4^k fits the rest.
  for (genvar i = 0; i < EW; i++) begin : g_stage
    localparam int K = EW - 1 - i;
    logic [DW+1:0]        trial;
    logic [DW-1:0]        rem_r, rem_nxt;
    logic [EW-1:0]        root_r, root_nxt;
    logic signed [HW-1:0] h_r;
    logic [AW-1:0]        a_r;
    logic                 vld_r, nohit_r;

    always_comb begin
      trial    = ((DW+2)'(root_w[i]) << (K + 1)) + ((DW+2)'(1) << (2 * K));
      rem_nxt  = rem_w[i];
      root_nxt = root_w[i];
      if (trial <= (DW+2)'(rem_w[i])) begin
        rem_nxt     = rem_w[i] - trial[DW-1:0];
        root_nxt[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r   <= rem_nxt;
        root_r  <= root_nxt;
        h_r     <= h_w[i];
        a_r     <= a_w[i];
        nohit_r <= nohit_w[i];
      end
    end

    assign rem_w[i+1]   = rem_r;
    assign root_w[i+1]  = root_r;
    assign h_w[i+1]     = h_r;
    assign a_w[i+1]     = a_r;
    assign vld_w[i+1]   = vld_r;
    assign nohit_w[i+1] = nohit_r;
  end

  assign r_o.vld   = vld_w[EW];
  assign r_o.nohit = nohit_w[EW];
  assign r_o.h     = h_w[EW];
  assign r_o.a     = a_w[EW];
  assign r_o.root  = root_w[EW];

endmodule

// ===== rtl/rsi_div.sv =====
// Root selection, saturation test and restoring division for t.
// Depends on rsi_pkg.
module rsi_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  rsi_pkg::root_t  r_i,
  output rsi_pkg::res_t   res_o
);
  import rsi_pkg::*;

  // Select the near root if positive, else the far one.
  logic signed [NW-1:0] nh, ez, num1, num2, numsel;
  logic                 pos1, pos2;
  logic [NW-2:0]        numu;
  logic                 s0_vld_r, s0_nohit_r, s0_sat_r;
  logic [DVW-1:0]       s0_rem_r;
  logic [AW-1:0]        s0_a_r;

  always_comb begin
    nh     = -(NW'(r_i.h));
    ez     = $signed({{(NW-EW){1'b0}}, r_i.root});
    num1   = nh - ez;
    num2   = nh + ez;
    pos1   = !num1[NW-1] && (num1 != '0);
    pos2   = !num2[NW-1] && (num2 != '0);
    numsel = pos1 ? num1 : num2;
    numu   = numsel[NW-2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= r_i.vld;
    end
  end

  // t saturates when num * 2^FRAC_BITS reaches a * 2^DTW.
  always_ff @(posedge clk) begin
    if (en) begin
      s0_nohit_r <= r_i.nohit | !(pos1 | pos2);
      s0_sat_r   <= (DVW'(numu) >= (DVW'(r_i.a) << (DTW - FRAC_BITS)));
      s0_rem_r   <= DVW'(numu) << FRAC_BITS;
      s0_a_r     <= r_i.a;
    end
  end

  logic [DVW-1:0] rem_w   [DTW+1];
  logic [DTW-1:0] q_w     [DTW+1];
  logic [AW-1:0]  a_w     [DTW+1];
  logic           vld_w   [DTW+1];
  logic           nohit_w [DTW+1];
  logic           sat_w   [DTW+1];

  assign rem_w[0]   = s0_rem_r;
  assign q_w[0]     = '0;
  assign a_w[0]     = s0_a_r;
  assign vld_w[0]   = s0_vld_r;
  assign nohit_w[0] = s0_nohit_r;
  assign sat_w[0]   = s0_sat_r;

  // One quotient bit per stage, most significant first.
  for (genvar i = 0; i < DTW; i++) begin : g_stage
    localparam int K = DTW - 1 - i;
    logic [DVW-1:0] dv;
    logic [DVW-1:0] rem_r, rem_nxt;
    logic [DTW-1:0] q_r, q_nxt;
    logic [AW-1:0]  a_r;
    logic           vld_r, nohit_r, sat_r;

    always_comb begin
      dv      = DVW'(a_w[i]) << K;
      rem_nxt = rem_w[i];
      q_nxt   = q_w[i];
      if (rem_w[i] >= dv) begin
        rem_nxt  = rem_w[i] - dv;
        q_nxt[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r   <= rem_nxt;
        q_r     <= q_nxt;
        a_r     <= a_w[i];
        nohit_r <= nohit_w[i];
        sat_r   <= sat_w[i];
      end
    end

    assign rem_w[i+1]   = rem_r;
    assign q_w[i+1]     = q_r;
    assign a_w[i+1]     = a_r;
    assign vld_w[i+1]   = vld_r;
    assign nohit_w[i+1] = nohit_r;
    assign sat_w[i+1]   = sat_r;
  end

  // Final stage: apply the miss and saturation cases.
  logic           fin_vld_r, fin_hit_r;
  logic [DTW-1:0] fin_dist_r, fin_dist_nxt;

  always_comb begin
    if (nohit_w[DTW]) begin
      fin_dist_nxt = '0;
    end else if (sat_w[DTW]) begin
      fin_dist_nxt = '1;
    end else begin
      fin_dist_nxt = q_w[DTW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= vld_w[DTW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_hit_r  <= !nohit_w[DTW];
      fin_dist_r <= fin_dist_nxt;
    end
  end

  assign res_o.vld      = fin_vld_r;
  assign res_o.hit      = fin_hit_r;
  assign res_o.distance = fin_dist_r;

endmodule

// ===== rtl/ray_sphere_intersection_top.sv =====
// Ray/sphere intersection top: one request per cycle while the skid register is empty.
// Pipeline: 6 front-end stages, 66 square-root stages (one root bit each),
// 33 division stages (root selection, 31 quotient bits, final fixup), output register.
// A skid register behind the output lets one more result land while the output waits.
// Synchronous active-low reset empties the pipeline and both output registers.
// Depends on rsi_pkg, rsi_quad, rsi_sqrt, rsi_div and ray_sphere_intersection_top_macros.svh.
`include "ray_sphere_intersection_top_macros.svh"

module ray_sphere_intersection_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [rsi_pkg::CW-1:0]      in_ray_dir_x,
  input  logic signed [rsi_pkg::CW-1:0]      in_ray_dir_y,
  input  logic signed [rsi_pkg::CW-1:0]      in_ray_dir_z,
  input  logic signed [rsi_pkg::CW-1:0]      in_ray_origin_x,
  input  logic signed [rsi_pkg::CW-1:0]      in_ray_origin_y,
  input  logic signed [rsi_pkg::CW-1:0]      in_ray_origin_z,
  input  logic signed [rsi_pkg::CW-1:0]      in_center_x,
  input  logic signed [rsi_pkg::CW-1:0]      in_center_y,
  input  logic signed [rsi_pkg::CW-1:0]      in_center_z,
  input  logic [rsi_pkg::DTW-1:0]            in_sphere_radius,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic [rsi_pkg::DTW-1:0]            out_distance_t
);
  import rsi_pkg::*;

  logic  en;
  quad_t quad;
  root_t root;
  res_t  res;

  // The whole pipeline moves unless the skid register is occupied.
  logic skid_vld_r, skid_vld_nxt;
  logic out_vld_r, out_vld_nxt;

  assign en       = !skid_vld_r;
  assign in_ready = en;

  rsi_quad u_quad (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .dir_i  ({in_ray_dir_z, in_ray_dir_y, in_ray_dir_x}),
    .org_i  ({in_ray_origin_z, in_ray_origin_y, in_ray_origin_x}),
    .ctr_i  ({in_center_z, in_center_y, in_center_x}),
    .rad_i  (in_sphere_radius),
    .q_o    (quad)
  );

  rsi_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .q_i   (quad),
    .r_o   (root)
  );

  rsi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .r_i   (root),
    .res_o (res)
  );

  // Output register with one skid entry.
  logic           take, push, to_out, load_skid, drain_skid;
  logic           out_hit_r, skid_hit_r;
  logic [DTW-1:0] out_dist_r, skid_dist_r;

  always_comb begin
    take         = out_vld_r && out_ready;
    push         = en && res.vld;
    to_out       = push && (!out_vld_r || take);
    load_skid    = push && out_vld_r && !take;
    drain_skid   = !push && take && skid_vld_r;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (to_out || drain_skid) begin
      out_vld_nxt = 1'b1;
    end else if (take) begin
      out_vld_nxt = 1'b0;
    end
    if (load_skid) begin
      skid_vld_nxt = 1'b1;
    end else if (drain_skid) begin
      skid_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (to_out) begin
      out_hit_r  <= res.hit;
      out_dist_r <= res.distance;
    end else if (drain_skid) begin
      out_hit_r  <= skid_hit_r;
      out_dist_r <= skid_dist_r;
    end
    if (load_skid) begin
      skid_hit_r  <= res.hit;
      skid_dist_r <= res.distance;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_hit        = out_hit_r;
  assign out_distance_t = out_dist_r;

  // A miss always reports a zero distance.
  `RSI_ASSERT_IMPL(a_miss_zero, out_vld_r && !out_hit_r, out_dist_r == '0, "miss with nonzero distance")
  // The skid entry is used only behind a full output register.
  `RSI_ASSERT_IMPL(a_skid_behind_out, skid_vld_r, out_vld_r, "skid entry without output")
  // Taking the output with a full skid moves the skid entry forward.
  `RSI_ASSERT_NEXT(a_skid_drain, skid_vld_r && out_ready, out_vld_r && !skid_vld_r, "skid not drained")

endmodule
